// ----- sv/ycc2rgb_pkg.sv -----
// Shared types and constants for the BT.601 YCbCr to RGB converter.
// No dependencies; used by every module of the block and by the checker.
package ycc2rgb_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_FULL_RANGE     = 2'd0;
    localparam logic [1:0] REG_SWAP_TO_BGR    = 2'd1;
    localparam logic [1:0] REG_INTEGER_OUTPUT = 2'd2;
    localparam logic [1:0] REG_ROUNDING       = 2'd3;

    // Rounding modes (code 3 falls back to truncation)
    localparam logic [1:0] ROUND_HALF_AWAY = 2'd0;
    localparam logic [1:0] ROUND_HALF_EVEN = 2'd1;
    localparam logic [1:0] ROUND_TRUNC     = 2'd2;

    // Register stages from an accepted start to the done strobe
    localparam int PIPE_LATENCY = 5;

    // Integer bits (with sign and headroom) above the coefficient fraction
    localparam int ACC_INT_BITS = 12;

    // Output field width
    localparam int CHAN_W = 16;

    // Coefficients in units of 1e-5
    localparam longint DEC_Y_LIM  = 116438;
    localparam longint DEC_RV_LIM = 159603;
    localparam longint DEC_GU_LIM = 39176;
    localparam longint DEC_GV_LIM = 81297;
    localparam longint DEC_BU_LIM = 201723;
    localparam longint DEC_RV_FUL = 140189;
    localparam longint DEC_GU_FUL = 34581;
    localparam longint DEC_GV_FUL = 71490;
    localparam longint DEC_BU_FUL = 177098;

    typedef struct packed {
        logic       full_range;
        logic       swap_to_bgr;
        logic       integer_output;
        logic [1:0] rounding;
    } cfg_t;

    // Round a decimal coefficient to nearest with frac fractional bits
    function automatic longint coef(input longint dec, input int frac);
        return ((dec << frac) + 64'sd50000) / 64'sd100000;
    endfunction

endpackage

// ----- sv/ycc2rgb_finish.sv -----
// One output channel: clamp to 0..255, then round to a byte or requantize.
// Two register stages. Depends on ycc2rgb_pkg.
module ycc2rgb_finish #(
    parameter int COEF_FRAC_BITS = 14,
    parameter int OUT_FRAC_BITS  = 8
) (
    input  logic                                                   clk,
    input  logic signed [COEF_FRAC_BITS+ycc2rgb_pkg::ACC_INT_BITS-1:0] acc,
    input  ycc2rgb_pkg::cfg_t                                      cfg,
    output logic [ycc2rgb_pkg::CHAN_W-1:0]                         result
);

    localparam int AW = COEF_FRAC_BITS + ycc2rgb_pkg::ACC_INT_BITS;
    localparam int VW = COEF_FRAC_BITS + 8;
    localparam int RW = OUT_FRAC_BITS + 8;
    localparam int EW = (RW > ycc2rgb_pkg::CHAN_W) ? RW : ycc2rgb_pkg::CHAN_W;
    localparam logic signed [AW-1:0] TOP = AW'(255) <<< COEF_FRAC_BITS;
    localparam logic [COEF_FRAC_BITS-1:0] HALF = {1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

    logic [VW-1:0]                    clamp_reg;
    logic [VW-1:0]                    clamp_next;
    logic [ycc2rgb_pkg::CHAN_W-1:0]   result_reg;
    logic [ycc2rgb_pkg::CHAN_W-1:0]   result_next;
    logic [7:0]                       ip;
    logic [COEF_FRAC_BITS-1:0]        frac;
    logic                             round_up;
    logic [8:0]                       ip_inc;
    logic [7:0]                       byte_val;
    logic [RW-1:0]                    requant;
    logic [EW-1:0]                    wide_val;

    // Clamp stage
    always_comb
    begin
        if (acc <= 0)
        begin
            clamp_next = '0;
        end
        else if (acc >= TOP)
        begin
            clamp_next = VW'(TOP);
        end
        else
        begin
            clamp_next = acc[VW-1:0];
        end
    end

    // Round stage
    assign ip   = clamp_reg[VW-1:COEF_FRAC_BITS];
    assign frac = clamp_reg[COEF_FRAC_BITS-1:0];

    always_comb
    begin
        case (cfg.rounding)
            ycc2rgb_pkg::ROUND_HALF_AWAY: round_up = (frac >= HALF);
            ycc2rgb_pkg::ROUND_HALF_EVEN: round_up = (frac > HALF) || ((frac == HALF) && ip[0]);
            default:                      round_up = 1'b0;
        endcase
    end

    assign ip_inc   = {1'b0, ip} + {8'd0, round_up};
    assign byte_val = ip_inc[8] ? 8'hFF : ip_inc[7:0];

    generate
        if (OUT_FRAC_BITS >= COEF_FRAC_BITS)
        begin : g_widen
            assign requant = RW'(clamp_reg) << (OUT_FRAC_BITS - COEF_FRAC_BITS);
        end
        else
        begin : g_narrow
            assign requant = RW'(clamp_reg >> (COEF_FRAC_BITS - OUT_FRAC_BITS));
        end
    endgenerate

    always_comb
    begin
        if (cfg.integer_output)
        begin
            wide_val = EW'(byte_val) << OUT_FRAC_BITS;
        end
        else
        begin
            wide_val = EW'(requant);
        end
        result_next = wide_val[ycc2rgb_pkg::CHAN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        clamp_reg  <= clamp_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- sv/ycbcr_to_rgb_bt601_top.sv -----
// Top level of the BT.601 YCbCr to RGB converter.
// Depends on ycc2rgb_pkg and ycc2rgb_finish.
//
// Usage:
//   Input channel: drive luma, chroma_blue and chroma_red with start high.
//   A pixel transfers at every rising edge with start high and busy low.
//   busy stays low: the pipeline takes a new pixel every cycle.
//   Result channel: done pulses for one cycle with first_channel,
//   second_channel and third_channel valid. The receiver cannot stall,
//   so sample the results in the cycle done is high.
//   Throughput is one pixel per clock; the pipeline has five register
//   stages (input capture, coefficient multiply, channel sum, clamp,
//   round).
//   Configuration: cfg_write with cfg_index and cfg_data updates one
//   register per edge. Write only while no pixel is in flight.
//   Reset (rst_n low, asynchronous): drop all pixels in flight and return
//   the registers to limited range, RGB order, integer output, half away
//   from zero.
module ycbcr_to_rgb_bt601_top #(
    parameter int COEF_FRAC_BITS = 14,
    parameter int OUT_FRAC_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  luma,
    input  logic [7:0]  chroma_blue,
    input  logic [7:0]  chroma_red,
    output logic        done,
    output logic [15:0] first_channel,
    output logic [15:0] second_channel,
    output logic [15:0] third_channel,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    localparam int CW  = COEF_FRAC_BITS + 2;
    localparam int AW  = COEF_FRAC_BITS + ycc2rgb_pkg::ACC_INT_BITS;
    localparam int LAT = ycc2rgb_pkg::PIPE_LATENCY;

    localparam logic [CW-1:0] C_Y_LIM  =
        CW'(ycc2rgb_pkg::coef(ycc2rgb_pkg::DEC_Y_LIM, COEF_FRAC_BITS));
    localparam logic [CW-1:0] C_RV_LIM =
        CW'(ycc2rgb_pkg::coef(ycc2rgb_pkg::DEC_RV_LIM, COEF_FRAC_BITS));
    localparam logic [CW-1:0] C_GU_LIM =
        CW'(ycc2rgb_pkg::coef(ycc2rgb_pkg::DEC_GU_LIM, COEF_FRAC_BITS));
    localparam logic [CW-1:0] C_GV_LIM =
        CW'(ycc2rgb_pkg::coef(ycc2rgb_pkg::DEC_GV_LIM, COEF_FRAC_BITS));
    localparam logic [CW-1:0] C_BU_LIM =
        CW'(ycc2rgb_pkg::coef(ycc2rgb_pkg::DEC_BU_LIM, COEF_FRAC_BITS));
    localparam logic [CW-1:0] C_Y_FUL  = CW'(1) << COEF_FRAC_BITS;
    localparam logic [CW-1:0] C_RV_FUL =
        CW'(ycc2rgb_pkg::coef(ycc2rgb_pkg::DEC_RV_FUL, COEF_FRAC_BITS));
    localparam logic [CW-1:0] C_GU_FUL =
        CW'(ycc2rgb_pkg::coef(ycc2rgb_pkg::DEC_GU_FUL, COEF_FRAC_BITS));
    localparam logic [CW-1:0] C_GV_FUL =
        CW'(ycc2rgb_pkg::coef(ycc2rgb_pkg::DEC_GV_FUL, COEF_FRAC_BITS));
    localparam logic [CW-1:0] C_BU_FUL =
        CW'(ycc2rgb_pkg::coef(ycc2rgb_pkg::DEC_BU_FUL, COEF_FRAC_BITS));

    // Configuration registers
    ycc2rgb_pkg::cfg_t cfg_reg;
    ycc2rgb_pkg::cfg_t cfg_next;

    // Valid bits, one per stage
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    // Stage 1: offset-removed samples
    logic signed [8:0] y_reg, y_next;
    logic signed [8:0] u_reg, u_next;
    logic signed [8:0] v_reg, v_next;

    // Stage 2: products
    logic signed [AW-1:0] ys_reg, ys_next;
    logic signed [AW-1:0] rv_reg, rv_next;
    logic signed [AW-1:0] gu_reg, gu_next;
    logic signed [AW-1:0] gv_reg, gv_next;
    logic signed [AW-1:0] bu_reg, bu_next;

    // Stage 3: channel sums in output order
    logic signed [AW-1:0] ch0_reg, ch0_next;
    logic signed [AW-1:0] ch1_reg, ch1_next;
    logic signed [AW-1:0] ch2_reg, ch2_next;

    logic [CW-1:0]        c_y, c_rv, c_gu, c_gv, c_bu;
    logic signed [AW-1:0] sum_r, sum_g, sum_b;

    // The pipeline never holds off a pixel
    assign busy = 1'b0;

    // Configuration writes: apply the addressed register, hold the rest
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ycc2rgb_pkg::REG_FULL_RANGE:     cfg_next.full_range     = cfg_data[0];
                ycc2rgb_pkg::REG_SWAP_TO_BGR:    cfg_next.swap_to_bgr    = cfg_data[0];
                ycc2rgb_pkg::REG_INTEGER_OUTPUT: cfg_next.integer_output = cfg_data[0];
                ycc2rgb_pkg::REG_ROUNDING:       cfg_next.rounding       = cfg_data;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    // Advance the valid bits one stage per cycle
    assign valid_next = {valid_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_range     <= 1'b0;
            cfg_reg.swap_to_bgr    <= 1'b0;
            cfg_reg.integer_output <= 1'b1;
            cfg_reg.rounding       <= ycc2rgb_pkg::ROUND_HALF_AWAY;
            valid_reg              <= '0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            valid_reg <= valid_next;
        end
    end

    // Stage 1: remove the chroma offsets, and the luma offset in limited range
    always_comb
    begin
        if (cfg_reg.full_range)
        begin
            y_next = $signed({1'b0, luma});
        end
        else
        begin
            y_next = $signed({1'b0, luma}) - 9'sd16;
        end
        u_next = $signed({1'b0, chroma_blue}) - 9'sd128;
        v_next = $signed({1'b0, chroma_red}) - 9'sd128;
    end

    // Stage 2: pick the coefficient set and multiply
    always_comb
    begin
        if (cfg_reg.full_range)
        begin
            c_y  = C_Y_FUL;
            c_rv = C_RV_FUL;
            c_gu = C_GU_FUL;
            c_gv = C_GV_FUL;
            c_bu = C_BU_FUL;
        end
        else
        begin
            c_y  = C_Y_LIM;
            c_rv = C_RV_LIM;
            c_gu = C_GU_LIM;
            c_gv = C_GV_LIM;
            c_bu = C_BU_LIM;
        end
        ys_next = AW'(y_reg) * $signed({{(AW-CW){1'b0}}, c_y});
        rv_next = AW'(v_reg) * $signed({{(AW-CW){1'b0}}, c_rv});
        gu_next = AW'(u_reg) * $signed({{(AW-CW){1'b0}}, c_gu});
        gv_next = AW'(v_reg) * $signed({{(AW-CW){1'b0}}, c_gv});
        bu_next = AW'(u_reg) * $signed({{(AW-CW){1'b0}}, c_bu});
    end

    // Stage 3: sum each channel and place it in output order
    always_comb
    begin
        sum_r = ys_reg + rv_reg;
        sum_g = ys_reg - gu_reg - gv_reg;
        sum_b = ys_reg + bu_reg;
        ch0_next = cfg_reg.swap_to_bgr ? sum_b : sum_r;
        ch1_next = sum_g;
        ch2_next = cfg_reg.swap_to_bgr ? sum_r : sum_b;
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
        ys_reg  <= ys_next;
        rv_reg  <= rv_next;
        gu_reg  <= gu_next;
        gv_reg  <= gv_next;
        bu_reg  <= bu_next;
        ch0_reg <= ch0_next;
        ch1_reg <= ch1_next;
        ch2_reg <= ch2_next;
    end

    // Stages 4 and 5: clamp, then round or requantize, per channel
    ycc2rgb_finish #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) u_finish0 (
        .clk    (clk),
        .acc    (ch0_reg),
        .cfg    (cfg_reg),
        .result (first_channel)
    );

    ycc2rgb_finish #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) u_finish1 (
        .clk    (clk),
        .acc    (ch1_reg),
        .cfg    (cfg_reg),
        .result (second_channel)
    );

    ycc2rgb_finish #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) u_finish2 (
        .clk    (clk),
        .acc    (ch2_reg),
        .cfg    (cfg_reg),
        .result (third_channel)
    );

    // Strobe each result transfer from the last valid bit
    assign done = valid_reg[LAT-1];

endmodule

// ----- sv/ycc2rgb_chk.sv -----
// Port-level checker for the YCbCr to RGB converter, bound to the top level.
// Depends on ycc2rgb_pkg and ycbcr_to_rgb_bt601_top.
module ycc2rgb_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // Pipeline takes a pixel every cycle
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised by a fully pipelined converter");

    // Every accepted pixel yields a result after the pipeline latency
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(ycc2rgb_pkg::PIPE_LATENCY) done)
        else $error("accepted pixel produced no result");

    // No result without a pixel accepted at the matching cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ycc2rgb_pkg::PIPE_LATENCY))
        else $error("result strobe without a matching transfer");

endmodule

bind ycbcr_to_rgb_bt601_top ycc2rgb_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

// ----- tb/sv/ycc2rgb_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the BT.601 YCbCr to RGB converter: predicts each pixel and compares.
// Depends on ycc2rgb_pkg for the register indexes, rounding codes and coefficient constants.
module ycc2rgb_checker #(
    parameter int COEF_FRAC_BITS = 14,
    parameter int OUT_FRAC_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  luma,
    input  logic [7:0]  chroma_blue,
    input  logic [7:0]  chroma_red,
    input  logic        done,
    input  logic [15:0] first_channel,
    input  logic [15:0] second_channel,
    input  logic [15:0] third_channel,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] first_ch;
        logic [15:0] second_ch;
        logic [15:0] third_ch;
    } rgb_pixel_t;

    rgb_pixel_t        expected_pixels[$];
    ycc2rgb_pkg::cfg_t cfg_shadow;

    function automatic longint scale_coef(input longint dec);
        return ((dec <<< COEF_FRAC_BITS) + 64'sd50000) / 64'sd100000;
    endfunction

    // Clamp to 0..255, then round to a byte or requantize the fraction to OUT_FRAC_BITS.
    function automatic logic [15:0] quantize_channel(input ycc2rgb_pkg::cfg_t c,
                                                     input longint acc);
        longint top;
        longint val;
        longint ip;
        longint frac;
        longint half;
        longint res;
        top  = longint'(255) <<< COEF_FRAC_BITS;
        val  = (acc <= 0) ? 0 : ((acc >= top) ? top : acc);
        if (c.integer_output) begin
            ip   = val >>> COEF_FRAC_BITS;
            frac = val & ((longint'(1) <<< COEF_FRAC_BITS) - 1);
            half = longint'(1) <<< (COEF_FRAC_BITS - 1);
            case (c.rounding)
                ycc2rgb_pkg::ROUND_HALF_AWAY: if (frac >= half) ip++;
                ycc2rgb_pkg::ROUND_HALF_EVEN:
                    if (frac > half || (frac == half && ip[0])) ip++;
                default: ;
            endcase
            if (ip > 255) ip = 255;
            res = ip <<< OUT_FRAC_BITS;
        end else if (OUT_FRAC_BITS >= COEF_FRAC_BITS) begin
            res = val <<< (OUT_FRAC_BITS - COEF_FRAC_BITS);
        end else begin
            res = val >>> (COEF_FRAC_BITS - OUT_FRAC_BITS);
        end
        return res[15:0];
    endfunction

    function automatic rgb_pixel_t convert_pixel(input ycc2rgb_pkg::cfg_t c,
                                                 input logic [7:0] y_in,
                                                 input logic [7:0] cb_in,
                                                 input logic [7:0] cr_in);
        longint     y;
        longint     u;
        longint     v;
        longint     ys;
        longint     red;
        longint     green;
        longint     blue;
        rgb_pixel_t px;
        y = longint'(y_in);
        u = longint'(cb_in) - 128;
        v = longint'(cr_in) - 128;
        if (c.full_range) begin
            ys    = y <<< COEF_FRAC_BITS;
            red   = ys + scale_coef(ycc2rgb_pkg::DEC_RV_FUL) * v;
            green = ys - scale_coef(ycc2rgb_pkg::DEC_GU_FUL) * u
                       - scale_coef(ycc2rgb_pkg::DEC_GV_FUL) * v;
            blue  = ys + scale_coef(ycc2rgb_pkg::DEC_BU_FUL) * u;
        end else begin
            ys    = scale_coef(ycc2rgb_pkg::DEC_Y_LIM) * (y - 16);
            red   = ys + scale_coef(ycc2rgb_pkg::DEC_RV_LIM) * v;
            green = ys - scale_coef(ycc2rgb_pkg::DEC_GU_LIM) * u
                       - scale_coef(ycc2rgb_pkg::DEC_GV_LIM) * v;
            blue  = ys + scale_coef(ycc2rgb_pkg::DEC_BU_LIM) * u;
        end
        px.first_ch  = quantize_channel(c, c.swap_to_bgr ? blue : red);
        px.second_ch = quantize_channel(c, green);
        px.third_ch  = quantize_channel(c, c.swap_to_bgr ? red : blue);
        return px;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        fail_count++;
        $display("[%0t] mismatch: %s got %h want %h", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rgb_pixel_t want;
        if (!rst_n) begin
            cfg_shadow.full_range     = 1'b0;
            cfg_shadow.swap_to_bgr    = 1'b0;
            cfg_shadow.integer_output = 1'b1;
            cfg_shadow.rounding       = ycc2rgb_pkg::ROUND_HALF_AWAY;
            expected_pixels.delete();
        end else begin
            // Compare the result leaving this cycle before taking in a new pixel.
            if (done === 1'b1) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result with no pixel pending", first_channel, 16'h0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (first_channel !== want.first_ch)
                        report_mismatch("first_channel", first_channel, want.first_ch);
                    if (second_channel !== want.second_ch)
                        report_mismatch("second_channel", second_channel, want.second_ch);
                    if (third_channel !== want.third_ch)
                        report_mismatch("third_channel", third_channel, want.third_ch);
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                expected_pixels.push_back(convert_pixel(cfg_shadow, luma, chroma_blue,
                                                        chroma_red));
            if (cfg_write === 1'b1) begin
                case (cfg_index)
                    ycc2rgb_pkg::REG_FULL_RANGE:
                        cfg_shadow.full_range     = cfg_data[0];
                    ycc2rgb_pkg::REG_SWAP_TO_BGR:
                        cfg_shadow.swap_to_bgr    = cfg_data[0];
                    ycc2rgb_pkg::REG_INTEGER_OUTPUT:
                        cfg_shadow.integer_output = cfg_data[0];
                    ycc2rgb_pkg::REG_ROUNDING:
                        cfg_shadow.rounding       = cfg_data;
                    default: ;
                endcase
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ----- tb/sv/tb_ycbcr_to_rgb_bt601_top.sv -----
`timescale 1ns / 1ps
// Top of the testbench for ycbcr_to_rgb_bt601_top: clock, reset, pixel and register stimulus.
// Depends on ycc2rgb_pkg, the block itself and ycc2rgb_checker, which predicts and compares.
module tb_ycbcr_to_rgb_bt601_top;

    // Round mode code with no meaning of its own; the block treats it as truncate.
    localparam logic [1:0] ROUND_RESERVED = 2'd3;

    localparam int NUM_PHASES     = 12;
    localparam int RANDOM_PER_SET = 105;
    // Boundaries of the sender idling schedule, counted in transfers.
    localparam int LIGHT_IDLE_END = 450;
    localparam int HEAVY_IDLE_END = 900;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  luma;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;
    logic        done;
    logic [15:0] first_channel;
    logic [15:0] second_channel;
    logic [15:0] third_channel;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [1:0]  cfg_data;
    int          fail_count;
    int          pending;
    int          sent_count;

    ycbcr_to_rgb_bt601_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .luma           (luma),
        .chroma_blue    (chroma_blue),
        .chroma_red     (chroma_red),
        .done           (done),
        .first_channel  (first_channel),
        .second_channel (second_channel),
        .third_channel  (third_channel),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // The checker sees every transfer and register write the block sees.
    ycc2rgb_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .luma           (luma),
        .chroma_blue    (chroma_blue),
        .chroma_red     (chroma_red),
        .done           (done),
        .first_channel  (first_channel),
        .second_channel (second_channel),
        .third_channel  (third_channel),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block stops answering.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    function automatic ycc2rgb_pkg::cfg_t make_cfg(input logic full, input logic swap,
                                                   input logic intg, input logic [1:0] rmode);
        ycc2rgb_pkg::cfg_t c;
        c.full_range     = full;
        c.swap_to_bgr    = swap;
        c.integer_output = intg;
        c.rounding       = rmode;
        return c;
    endfunction

    // Idle each cycle with the current odds, then present one pixel and hold
    // it until it transfers.
    // Idle odds: light in the first stretch, heavy in the second, none after that.
    task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr);
        int idle_pct;
        if (sent_count < LIGHT_IDLE_END)
            idle_pct = 17;
        else if (sent_count < HEAVY_IDLE_END)
            idle_pct = 56;
        else
            idle_pct = 0;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        luma        <= y;
        chroma_blue <= cb;
        chroma_red  <= cr;
        do @(posedge clk); while (busy !== 1'b0);
        sent_count++;
    endtask

    // Drop start, hold off until every predicted pixel has come back,
    // and let the clock run on with start low before anything else.
    task automatic drain_pipeline();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (ycc2rgb_pkg::PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_cfg_reg(input logic [1:0] index, input logic [1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Write all four registers back to back; the unused upper bit of the
    // one-bit registers gets random junk, which the block must drop.
    task automatic apply_setting(input ycc2rgb_pkg::cfg_t s);
        write_cfg_reg(ycc2rgb_pkg::REG_FULL_RANGE, {1'($urandom_range(1)), s.full_range});
        write_cfg_reg(ycc2rgb_pkg::REG_SWAP_TO_BGR, {1'($urandom_range(1)), s.swap_to_bgr});
        write_cfg_reg(ycc2rgb_pkg::REG_INTEGER_OUTPUT,
                      {1'($urandom_range(1)), s.integer_output});
        write_cfg_reg(ycc2rgb_pkg::REG_ROUNDING, s.rounding);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly uniform pixels; some grey ones and some with chroma at the rails.
    task automatic pick_pixel(output logic [7:0] y, output logic [7:0] cb,
                              output logic [7:0] cr);
        logic [7:0] rails [6];
        int         kind;
        rails = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        kind  = $urandom_range(99);
        y     = 8'($urandom_range(255));
        if (kind < 70) begin
            cb = 8'($urandom_range(255));
            cr = 8'($urandom_range(255));
        end else if (kind < 85) begin
            cb = 8'd128;
            cr = 8'd128;
        end else begin
            cb = rails[$urandom_range(5)];
            cr = rails[$urandom_range(5)];
        end
    endtask

    initial
    begin
        ycc2rgb_pkg::cfg_t phase_cfg [NUM_PHASES];
        logic [7:0]        dir_y  [16];
        logic [7:0]        dir_cb [16];
        logic [7:0]        dir_cr [16];
        logic [7:0]        y;
        logic [7:0]        cb;
        logic [7:0]        cr;

        // Settings cover every register value, the reset setting first.
        phase_cfg[0]  = make_cfg(1'b0, 1'b0, 1'b1, ycc2rgb_pkg::ROUND_HALF_AWAY);
        phase_cfg[1]  = make_cfg(1'b0, 1'b1, 1'b1, ycc2rgb_pkg::ROUND_HALF_EVEN);
        phase_cfg[2]  = make_cfg(1'b1, 1'b0, 1'b1, ycc2rgb_pkg::ROUND_TRUNC);
        phase_cfg[3]  = make_cfg(1'b1, 1'b1, 1'b1, ROUND_RESERVED);
        phase_cfg[4]  = make_cfg(1'b0, 1'b0, 1'b0, ycc2rgb_pkg::ROUND_HALF_AWAY);
        phase_cfg[5]  = make_cfg(1'b1, 1'b1, 1'b0, ycc2rgb_pkg::ROUND_HALF_EVEN);
        phase_cfg[6]  = make_cfg(1'b1, 1'b0, 1'b1, ycc2rgb_pkg::ROUND_HALF_AWAY);
        phase_cfg[7]  = make_cfg(1'b0, 1'b1, 1'b1, ROUND_RESERVED);
        phase_cfg[8]  = make_cfg(1'b1, 1'b0, 1'b0, ycc2rgb_pkg::ROUND_TRUNC);
        phase_cfg[9]  = make_cfg(1'b0, 1'b0, 1'b1, ycc2rgb_pkg::ROUND_HALF_EVEN);
        phase_cfg[10] = make_cfg(1'b1, 1'b1, 1'b1, ycc2rgb_pkg::ROUND_HALF_EVEN);
        phase_cfg[11] = make_cfg(1'b0, 1'b1, 1'b0, ROUND_RESERVED);

        // Directed pixels: black and white in both ranges, grey axis ends,
        // saturated primaries, chroma rails that drive every channel past
        // both clamps, and a few ordinary colors.
        dir_y  = '{8'd0,   8'd255, 8'd16,  8'd235, 8'd0,   8'd255, 8'd81,  8'd145,
                   8'd41,  8'd255, 8'd0,   8'd128, 8'd128, 8'd17,  8'd170, 8'd106};
        dir_cb = '{8'd0,   8'd255, 8'd128, 8'd128, 8'd128, 8'd128, 8'd90,  8'd54,
                   8'd240, 8'd0,   8'd255, 8'd0,   8'd255, 8'd129, 8'd166, 8'd202};
        dir_cr = '{8'd0,   8'd255, 8'd128, 8'd128, 8'd128, 8'd128, 8'd240, 8'd34,
                   8'd110, 8'd255, 8'd0,   8'd0,   8'd255, 8'd127, 8'd16,  8'd222};

        sent_count = 0;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        luma        <= 8'd0;
        chroma_blue <= 8'd0;
        chroma_red  <= 8'd0;
        cfg_write   <= 1'b0;
        cfg_index   <= ycc2rgb_pkg::REG_FULL_RANGE;
        cfg_data    <= 2'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels run on the reset setting, no register written yet.
        for (int i = 0; i < 16; i++)
            send_pixel(dir_y[i], dir_cb[i], dir_cr[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_pipeline();
            apply_setting(phase_cfg[p]);
            // Corners of the input cube under every setting.
            for (int k = 0; k < 8; k++)
                send_pixel(k[0] ? 8'd255 : 8'd0, k[1] ? 8'd255 : 8'd0, k[2] ? 8'd255 : 8'd0);
            for (int n = 0; n < RANDOM_PER_SET; n++) begin
                // Halfway through, pause until the pipeline is empty.
                if (n == RANDOM_PER_SET / 2)
                    drain_pipeline();
                pick_pixel(y, cb, cr);
                send_pixel(y, cb, cr);
            end
        end

        drain_pipeline();
        repeat (ycc2rgb_pkg::PIPE_LATENCY * 2) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
